// ----- src/sose_pkg.sv -----
`default_nettype none

package sose_pkg;

	// Configuration port
	localparam int CFG_IW = 2;
	localparam int CFG_DW = 24;

	localparam logic [CFG_IW-1:0] REG_LINE_LENGTH = 2'd0;
	localparam logic [CFG_IW-1:0] REG_LINE_COUNT  = 2'd1;
	localparam logic [CFG_IW-1:0] REG_KEY_COLOR   = 2'd2;

	// Field widths
	localparam int PIX_W   = 24;
	localparam int LEN_W   = 13;
	localparam int IDX_W   = 12;
	localparam int START_W = 12;
	localparam int SPAN_W  = 13;
	localparam int SIZE_W  = 13;

	localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

	// Record kinds
	localparam logic REC_SPAN  = 1'b0;
	localparam logic REC_BLOCK = 1'b1;

	typedef struct packed {
		logic               record_type;
		logic [IDX_W-1:0]   line_index;
		logic [START_W-1:0] span_start;
		logic [SPAN_W-1:0]  span_length;
		logic [SIZE_W-1:0]  block_size;
		logic               last;
	} rec_t;

endpackage

`default_nettype wire

// ----- src/scanline_opaque_span_extractor_top.sv -----
`default_nettype none

// Opaque span extractor. Pixels come in scan-line order, one per transfer on the
// in_* channel; a pixel is opaque when it differs from key_color. At each line end
// the block issues a span record (first opaque position and length to the last
// opaque pixel, or start 0 and the line length for a blank line), then the block
// record of a run of equal lines that this line closes, then at the image's last
// line the record of the run holding that line; last marks the final record of the
// pixel. The accepted pixel sits in an input register, where the per-pixel compares
// and counter updates run, so one pixel is taken every cycle while no line-end pixel
// waits there. A line end loads its one to three records at once into a three-entry
// result bank that drains one record per output transfer; the next line end waits
// until the bank is empty or its final record leaves, while pixels inside a line keep
// flowing. Short lines let the single output port set the rate: with a line length of
// one every pixel ends a line and waits for the records before it to drain, and a line
// of two pixels whose end issues three records stalls the input. Configuration
// writes take effect at once and are meant for idle periods only; a length or count
// of zero acts as one and one above the parameter acts as the parameter.
module scanline_opaque_span_extractor_top #(
	parameter int MAX_LINE_PIXELS = 4096,
	parameter int MAX_LINES       = 4096
) (
	input  wire                          clk,
	input  wire                          arst_n,
	// configuration
	input  wire                          cfg_we,
	input  wire [sose_pkg::CFG_IW-1:0]   cfg_index,
	input  wire [sose_pkg::CFG_DW-1:0]   cfg_data,
	// pixel channel
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire [sose_pkg::PIX_W-1:0]    pixel,
	// record channel
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic                         record_type,
	output logic [sose_pkg::IDX_W-1:0]   line_index,
	output logic [sose_pkg::START_W-1:0] span_start,
	output logic [sose_pkg::SPAN_W-1:0]  span_length,
	output logic [sose_pkg::SIZE_W-1:0]  block_size,
	output logic                         last
);
	import sose_pkg::*;

	localparam int PW  = $clog2(MAX_LINE_PIXELS);          // pixel position
	localparam int LW  = PW + 1;                           // span length
	localparam int LCW = (LW > LEN_W) ? LW : LEN_W;        // length compare
	localparam int NW  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1; // line number
	localparam int NCW = ((NW + 1) > LEN_W) ? (NW + 1) : LEN_W;   // count compare

	// Registers
	logic [LEN_W-1:0] line_length_q;
	logic [LEN_W-1:0] line_count_q;
	logic [PIX_W-1:0] key_color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= LEN_W'(4096);
			line_count_q  <= LEN_W'(4096);
			key_color_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LINE_LENGTH: line_length_q <= cfg_data[LEN_W-1:0];
				REG_LINE_COUNT:  line_count_q  <= cfg_data[LEN_W-1:0];
				REG_KEY_COLOR:   key_color_q   <= cfg_data[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the registers into the working range
	logic [LCW-1:0] len_wide;
	logic [LW-1:0]  len_eff;
	logic [NCW-1:0] cnt_wide;
	logic [NCW-1:0] cnt_eff;

	always_comb begin
		len_wide = LCW'(line_length_q);
		if (len_wide == '0)
			len_wide = LCW'(1);
		else if (len_wide > LCW'(MAX_LINE_PIXELS))
			len_wide = LCW'(MAX_LINE_PIXELS);
		len_eff = LW'(len_wide);

		cnt_eff = NCW'(line_count_q);
		if (cnt_eff == '0)
			cnt_eff = NCW'(1);
		else if (cnt_eff > NCW'(MAX_LINES))
			cnt_eff = NCW'(MAX_LINES);
	end

	// Input register
	logic             vld_s1;
	logic [PIX_W-1:0] pix_s1;
	logic             in_xfer;
	logic             adv;

	// Line and block state
	logic [PW-1:0]     pos_q;
	logic [NW-1:0]     line_q;
	logic              found_q;
	logic [PW-1:0]     first_q;
	logic [PW-1:0]     last_q;
	logic [NW-1:0]     blk_line_q;
	logic [PW-1:0]     blk_start_q;
	logic [LW-1:0]     blk_len_q;
	logic [SIZE_W-1:0] blk_cnt_q;

	// Result bank: entry 0 is on the output
	rec_t     rec_q [3];
	logic [1:0] rem_q;
	logic       out_xfer;
	logic       bank_free;

	assign out_xfer  = out_valid && !out_stall;
	assign bank_free = (rem_q == 2'd0) || ((rem_q == 2'd1) && out_xfer);
	assign in_xfer   = in_valid && !in_stall;

	// Per-pixel work
	logic           opaque;
	logic           found_n;
	logic [PW-1:0]  first_n;
	logic [PW-1:0]  last_n;
	logic [LCW-1:0] pos_inc;
	logic           line_end;
	logic [NCW-1:0] line_inc;
	logic           img_end;
	logic [PW-1:0]  s_val;
	logic [LW-1:0]  l_val;
	logic           merge;
	logic           close;
	logic [NW-1:0]     nb_line;
	logic [PW-1:0]     nb_start;
	logic [LW-1:0]     nb_len;
	logic [SIZE_W-1:0] nb_cnt;
	rec_t           r_span;
	rec_t           r_close;
	rec_t           r_final;
	rec_t           new_rec [3];
	logic [1:0]     new_n;

	always_comb begin
		opaque  = pix_s1 != key_color_q;
		found_n = found_q || opaque;
		first_n = found_q ? first_q : pos_q;
		last_n  = opaque ? pos_q : last_q;

		pos_inc  = LCW'(pos_q) + LCW'(1);
		line_end = pos_inc >= LCW'(len_eff);
		line_inc = NCW'(line_q) + NCW'(1);
		img_end  = line_inc >= cnt_eff;

		if (found_n) begin
			s_val = first_n;
			l_val = LW'(last_n) - LW'(first_n) + LW'(1);
		end else begin
			s_val = '0;
			l_val = len_eff;
		end

		merge = (blk_cnt_q != '0) && (s_val == blk_start_q) && (l_val == blk_len_q);
		close = (blk_cnt_q != '0) && !merge;

		if (merge) begin
			nb_line  = blk_line_q;
			nb_start = blk_start_q;
			nb_len   = blk_len_q;
			nb_cnt   = (blk_cnt_q < SIZE_MAX) ? blk_cnt_q + SIZE_W'(1) : blk_cnt_q;
		end else begin
			nb_line  = line_q;
			nb_start = s_val;
			nb_len   = l_val;
			nb_cnt   = SIZE_W'(1);
		end

		r_span.record_type = REC_SPAN;
		r_span.line_index  = IDX_W'(line_q);
		r_span.span_start  = START_W'(s_val);
		r_span.span_length = SPAN_W'(l_val);
		r_span.block_size  = '0;
		r_span.last        = 1'b0;

		r_close.record_type = REC_BLOCK;
		r_close.line_index  = IDX_W'(blk_line_q);
		r_close.span_start  = START_W'(blk_start_q);
		r_close.span_length = SPAN_W'(blk_len_q);
		r_close.block_size  = blk_cnt_q;
		r_close.last        = 1'b0;

		r_final.record_type = REC_BLOCK;
		r_final.line_index  = IDX_W'(nb_line);
		r_final.span_start  = START_W'(nb_start);
		r_final.span_length = SPAN_W'(nb_len);
		r_final.block_size  = nb_cnt;
		r_final.last        = 1'b0;

		// Pack the records in issue order and mark the final one
		new_rec[0] = r_span;
		new_rec[1] = close ? r_close : r_final;
		new_rec[2] = r_final;
		new_n      = 2'd1 + {1'b0, close} + {1'b0, img_end};
		case (new_n)
			2'd1:    new_rec[0].last = 1'b1;
			2'd2:    new_rec[1].last = 1'b1;
			default: new_rec[2].last = 1'b1;
		endcase
	end

	// Hold a line-end pixel until the bank can take all its records
	assign adv      = vld_s1 && (!line_end || bank_free);
	assign in_stall = vld_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_xfer) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer)
			pix_s1 <= pixel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			line_q      <= '0;
			found_q     <= 1'b0;
			first_q     <= '0;
			last_q      <= '0;
			blk_line_q  <= '0;
			blk_start_q <= '0;
			blk_len_q   <= '0;
			blk_cnt_q   <= '0;
		end else if (adv) begin
			if (!line_end) begin
				pos_q   <= PW'(pos_inc);
				found_q <= found_n;
				first_q <= first_n;
				last_q  <= last_n;
			end else begin
				// close the line, start the next one clean
				pos_q       <= '0;
				found_q     <= 1'b0;
				first_q     <= '0;
				last_q      <= '0;
				blk_line_q  <= nb_line;
				blk_start_q <= nb_start;
				blk_len_q   <= nb_len;
				if (img_end) begin
					blk_cnt_q <= '0;
					line_q    <= '0;
				end else begin
					blk_cnt_q <= nb_cnt;
					line_q    <= NW'(line_inc);
				end
			end
		end
	end

	// Result bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
		end else if (adv && line_end) begin
			rem_q <= new_n;
		end else if (out_xfer) begin
			rem_q <= rem_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && line_end) begin
			rec_q[0] <= new_rec[0];
			rec_q[1] <= new_rec[1];
			rec_q[2] <= new_rec[2];
		end else if (out_xfer) begin
			// advance the queue by one record
			rec_q[0] <= rec_q[1];
			rec_q[1] <= rec_q[2];
		end
	end

	assign out_valid   = rem_q != 2'd0;
	assign record_type = rec_q[0].record_type;
	assign line_index  = rec_q[0].line_index;
	assign span_start  = rec_q[0].span_start;
	assign span_length = rec_q[0].span_length;
	assign block_size  = rec_q[0].block_size;
	assign last        = rec_q[0].last;

endmodule

`default_nettype wire

// ----- src/sose_checker.sv -----
`default_nettype none

module sose_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          cfg_we,
	input wire [sose_pkg::CFG_IW-1:0]   cfg_index,
	input wire [sose_pkg::CFG_DW-1:0]   cfg_data,
	input wire                          in_valid,
	input wire                          in_stall,
	input wire [sose_pkg::PIX_W-1:0]    pixel,
	input wire                          out_valid,
	input wire                          out_stall,
	input wire                          record_type,
	input wire [sose_pkg::IDX_W-1:0]    line_index,
	input wire [sose_pkg::START_W-1:0]  span_start,
	input wire [sose_pkg::SPAN_W-1:0]   span_length,
	input wire [sose_pkg::SIZE_W-1:0]   block_size,
	input wire                          last
);
	import sose_pkg::*;

	// Hold a stalled record
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("record dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(record_type) && $stable(line_index)
			&& $stable(span_start) && $stable(span_length)
			&& $stable(block_size) && $stable(last))
		else $error("stalled record changed");

	// Records of one pixel leave back to back
	a_group_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("gap inside a record group");

	// Only block records follow a span record of the same pixel
	a_after_span: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last && record_type == REC_SPAN
			|=> record_type == REC_BLOCK)
		else $error("span record followed by a span record");

endmodule

bind scanline_opaque_span_extractor_top sose_checker u_sose_checker (.*);

`default_nettype wire

// ----- tb/scanline_opaque_span_extractor_top_test.sv -----
`timescale 1ns / 1ps

module scanline_opaque_span_extractor_top_test;
	import sose_pkg::*;

	localparam int MAX_PIX  = 4096;
	localparam int MAX_ROWS = 4096;
	// index with no register behind it; writes there must change nothing
	localparam logic [CFG_IW-1:0] REG_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS   = 310;
	// input register plus the result bank, with margin
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               cfg_we = 1'b0;
	logic [CFG_IW-1:0]  cfg_index = '0;
	logic [CFG_DW-1:0]  cfg_data = '0;

	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [PIX_W-1:0]   pixel = '0;

	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               record_type;
	logic [IDX_W-1:0]   line_index;
	logic [START_W-1:0] span_start;
	logic [SPAN_W-1:0]  span_length;
	logic [SIZE_W-1:0]  block_size;
	logic               last;

	scanline_opaque_span_extractor_top #(
		.MAX_LINE_PIXELS(MAX_PIX),
		.MAX_LINES(MAX_ROWS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel(pixel),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.record_type(record_type),
		.line_index(line_index),
		.span_start(span_start),
		.span_length(span_length),
		.block_size(block_size),
		.last(last)
	);

	always #10 clk = ~clk;

	// Pixels waiting to be driven, and the records the scan tracker expects next.
	logic [PIX_W-1:0] pixel_feed[$];
	rec_t             pending_records[$];

	int unsigned mismatches = 0;
	bit          steady = 1'b0;     // no idling on either side while set
	bit          alpha_mode = 1'b0; // pixels are alpha bytes against a zero key
	int          shape_lo, shape_hi; // opaque extent of the line being built

	// Register copies, at the block's widths and reset values.
	logic [LEN_W-1:0] cfg_len   = 13'd4096;
	logic [LEN_W-1:0] cfg_lines = 13'd4096;
	logic [PIX_W-1:0] cfg_key   = '0;

	// Scan state of the tracker.
	logic [IDX_W-1:0]   col_pos = '0;
	logic [IDX_W-1:0]   row_num = '0;
	logic               seen_opaque = 1'b0;
	logic [IDX_W-1:0]   first_op = '0;
	logic [IDX_W-1:0]   last_op = '0;
	logic [IDX_W-1:0]   run_first_row = '0;
	logic [START_W-1:0] run_start = '0;
	logic [SPAN_W-1:0]  run_length = '0;
	logic [SIZE_W-1:0]  run_lines = '0; // zero while no run of equal lines is open

	function automatic rec_t run_record();
		rec_t r;
		r = '0;
		r.record_type = REC_BLOCK;
		r.line_index  = run_first_row;
		r.span_start  = run_start;
		r.span_length = run_length;
		r.block_size  = run_lines;
		return r;
	endfunction

	// Advance the scan by one pixel and queue the records that its line end gives.
	task automatic track_pixel(input logic [PIX_W-1:0] value);
		int   width, rows, s, l;
		rec_t r;
		rec_t recs[$];
		// out-of-range register values act as the nearest bound
		width = (cfg_len == 0) ? 1 : ((cfg_len > MAX_PIX) ? MAX_PIX : int'(cfg_len));
		rows  = (cfg_lines == 0) ? 1 : ((cfg_lines > MAX_ROWS) ? MAX_ROWS : int'(cfg_lines));
		if (value != cfg_key) begin
			if (!seen_opaque) begin
				seen_opaque = 1'b1;
				first_op = col_pos;
			end
			last_op = col_pos;
		end
		if (int'(col_pos) + 1 < width) begin
			col_pos++;
			return;
		end
		// line end: a blank line spans the whole line from position zero
		if (seen_opaque) begin
			s = int'(first_op);
			l = int'(last_op) - int'(first_op) + 1;
		end else begin
			s = 0;
			l = width;
		end
		r = '0;
		r.record_type = REC_SPAN;
		r.line_index  = row_num;
		r.span_start  = START_W'(s);
		r.span_length = SPAN_W'(l);
		recs.push_back(r);
		col_pos = '0;
		seen_opaque = 1'b0;
		first_op = '0;
		last_op = '0;
		// extend the open run on an equal line, otherwise close it and open another
		if (run_lines != 0 && s == int'(run_start) && l == int'(run_length)) begin
			if (run_lines != SIZE_MAX)
				run_lines++;
		end else begin
			if (run_lines != 0)
				recs.push_back(run_record());
			run_first_row = row_num;
			run_start = START_W'(s);
			run_length = SPAN_W'(l);
			run_lines = SIZE_W'(1);
		end
		// image end flushes the run holding the final line
		if (int'(row_num) + 1 >= rows) begin
			recs.push_back(run_record());
			run_lines = '0;
			row_num = '0;
		end else begin
			row_num++;
		end
		recs[$].last = 1'b1;
		foreach (recs[i])
			pending_records.push_back(recs[i]);
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_record(input rec_t got);
		rec_t want;
		if (pending_records.size() == 0) begin
			$error("record with nothing expected: type %0d line %0d start %0d length %0d",
				got.record_type, got.line_index, got.span_start, got.span_length);
			mismatches++;
			return;
		end
		want = pending_records.pop_front();
		check_field("record_type", want.record_type, got.record_type);
		check_field("line_index", want.line_index, got.line_index);
		check_field("span_start", want.span_start, got.span_start);
		check_field("span_length", want.span_length, got.span_length);
		check_field("block_size", want.block_size, got.block_size);
		check_field("last", want.last, got.last);
	endtask

	// Pixel driver: hold the payload while stalled, draw a gap before each transfer.
	int unsigned feed_wait = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			pixel <= '0;
			feed_wait <= 0;
		end else begin
			if (in_valid && !in_stall)
				track_pixel(pixel);
			if (!in_valid || !in_stall) begin
				if (feed_wait != 0) begin
					feed_wait <= feed_wait - 1;
					in_valid <= 1'b0;
				end else if (pixel_feed.size() != 0) begin
					pixel <= pixel_feed.pop_front();
					in_valid <= 1'b1;
					feed_wait <= steady ? 0 : $urandom_range(0, 5);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Record monitor: check each transfer, then stall for a drawn number of cycles.
	int unsigned stall_left = 0;

	always @(posedge clk or negedge arst_n) begin : record_monitor
		int unsigned hold;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (out_valid && !out_stall) begin
			check_record({record_type, line_index, span_start, span_length, block_size, last});
			hold = steady ? 0 : $urandom_range(0, 5);
			stall_left <= hold;
			out_stall <= (hold != 0);
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= (stall_left > 1);
		end
	end

	// Watchdog: give up after a long stretch with no transfer on either channel.
	int unsigned quiet = 0;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else if (quiet >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// Write one register; the tracker's copy follows at once since the block is idle.
	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
		REG_LINE_LENGTH: cfg_len = value[LEN_W-1:0];
		REG_LINE_COUNT:  cfg_lines = value[LEN_W-1:0];
		REG_KEY_COLOR:   cfg_key = value[PIX_W-1:0];
		default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait for every pixel to go in and every record to come out, then let the
	// pipeline settle, since a mid-line pixel leaves nothing to wait for.
	task automatic drain_block();
		do
			@(posedge clk);
		while (pixel_feed.size() != 0 || in_valid || pending_records.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [PIX_W-1:0] opaque_value();
		logic [PIX_W-1:0] v;
		if (alpha_mode)
			return PIX_W'($urandom_range(1, 255));
		// often one bit away from the key, so each key bit gets to matter
		if ($urandom_range(0, 2) == 0)
			return cfg_key ^ (PIX_W'(1) << $urandom_range(0, PIX_W - 1));
		do
			v = PIX_W'($urandom);
		while (v == cfg_key);
		return v;
	endfunction

	// Queue one line; a reused shape gives an equal span with fresh colours.
	task automatic feed_line(input int width, input bit reuse_shape);
		int p;
		if (!reuse_shape) begin
			case ($urandom_range(0, 3))
			0: begin
				shape_lo = -1;
				shape_hi = -1;
			end
			1: begin
				shape_lo = $urandom_range(0, width - 1);
				shape_hi = shape_lo;
			end
			default: begin
				shape_lo = $urandom_range(0, width - 1);
				shape_hi = $urandom_range(shape_lo, width - 1);
			end
			endcase
		end
		for (p = 0; p < width; p++) begin
			if (p == shape_lo || p == shape_hi)
				pixel_feed.push_back(opaque_value());
			else if (p > shape_lo && p < shape_hi && $urandom_range(0, 1) == 1)
				pixel_feed.push_back(opaque_value());
			else
				pixel_feed.push_back(cfg_key);
		end
	endtask

	initial begin
		int          width, n_lines, n_pix, i;
		logic [12:0] len_sel, count_sel;
		int unsigned random_items;
		random_items = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: two blank lines merging from line 0, a line opaque only at both ends
		// whose span equals the blank ones, then a line that closes the run and ends the
		// image with three records from one pixel.
		write_reg(REG_LINE_LENGTH, 24'd4);
		write_reg(REG_LINE_COUNT, 24'd4);
		write_reg(REG_KEY_COLOR, 24'h123456);
		repeat (8) pixel_feed.push_back(24'h123456);
		pixel_feed.push_back(24'h000000);
		pixel_feed.push_back(24'h123456);
		pixel_feed.push_back(24'h123456);
		pixel_feed.push_back(24'h123457);
		pixel_feed.push_back(24'h123456);
		pixel_feed.push_back(24'hFFFFFF);
		pixel_feed.push_back(24'h123456);
		pixel_feed.push_back(24'h123456);
		drain_block();

		// one-pixel lines in one-line images: blank, white and alpha-byte pixels against a zero key
		write_reg(REG_LINE_LENGTH, 24'd1);
		write_reg(REG_LINE_COUNT, 24'd1);
		write_reg(REG_KEY_COLOR, 24'h000000);
		pixel_feed.push_back(24'h000000);
		pixel_feed.push_back(24'hFFFFFF);
		pixel_feed.push_back(24'h000080);
		drain_block();

		// Random phases: mostly whole images with repeated line shapes so runs form,
		// some ragged pixel bursts that leave the scan mid-line.
		while (random_items < RANDOM_ITEMS) begin
			steady = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 7))
			0: len_sel = 13'd0;
			1: len_sel = 13'd1;
			default: len_sel = 13'($urandom_range(2, 12));
			endcase
			case ($urandom_range(0, 9))
			0: count_sel = 13'd0;
			1: count_sel = 13'($urandom_range(4097, 8191));
			default: count_sel = 13'($urandom_range(1, 6));
			endcase
			// upper data bits are beyond the register and must be dropped
			write_reg(REG_LINE_LENGTH, 24'($urandom) & 24'hFFE000 | 24'(len_sel));
			write_reg(REG_LINE_COUNT, 24'($urandom) & 24'hFFE000 | 24'(count_sel));
			case ($urandom_range(0, 5))
			0, 1: begin
				alpha_mode = 1'b1;
				write_reg(REG_KEY_COLOR, 24'h000000);
			end
			2: begin
				alpha_mode = 1'b0;
				write_reg(REG_KEY_COLOR, 24'hFFFFFF);
			end
			default: begin
				alpha_mode = 1'b0;
				write_reg(REG_KEY_COLOR, 24'($urandom));
			end
			endcase
			if ($urandom_range(0, 7) == 0)
				write_reg(REG_UNUSED, 24'($urandom));

			width = (len_sel == 0) ? 1 : int'(len_sel);
			if ($urandom_range(0, 4) == 0) begin
				n_pix = $urandom_range(1, 2 * width);
				for (i = 0; i < n_pix; i++)
					pixel_feed.push_back($urandom_range(0, 1) ? opaque_value() : cfg_key);
			end else begin
				if (count_sel >= 1 && count_sel <= 6)
					n_lines = int'(count_sel) * $urandom_range(1, 2);
				else
					n_lines = $urandom_range(1, 3);
				n_pix = n_lines * width;
				for (i = 0; i < n_lines; i++)
					feed_line(width, i != 0 && $urandom_range(0, 1) == 1);
			end
			random_items += n_pix;
			drain_block();
		end

		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
